>>> src/wvel_pkg.sv
// ----------------------------------------------------------------------------
// wvel_pkg
// shared widths, constants and state type of the windowed velocity estimator
// ----------------------------------------------------------------------------
package wvel_pkg;

    localparam int MAX_WINDOW = 16;
    localparam int IDX_W      = $clog2(MAX_WINDOW);
    localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
    localparam int POS_W      = 12;
    localparam int DELTA_W    = 13;
    localparam int SUM_W      = DELTA_W + IDX_W;
    localparam int RAM_W      = 2 * DELTA_W;
    localparam int WLEN_W     = 5;
    localparam int CMP_W      = (CNT_W > WLEN_W) ? CNT_W : WLEN_W;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 32;
    localparam int M_TUSER_W  = 2;

    localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(8);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SUB,
        ST_CHECK,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

>>> src/wvel_ram.sv
// ----------------------------------------------------------------------------
// wvel_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module wvel_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> src/wvel_div.sv
// ----------------------------------------------------------------------------
// wvel_div
// radix-2 restoring divider, signed sum by unsigned count, truncates toward zero
// ----------------------------------------------------------------------------
module wvel_div import wvel_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic signed [SUM_W-1:0]   dividend,
    input  logic [CNT_W-1:0]          divisor,
    output logic                      done,
    output logic signed [DELTA_W-1:0] quotient
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic               busy_reg;
    logic               done_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               neg_reg;
    logic [SUM_W-1:0]   mag_reg;
    logic [CNT_W-1:0]   rem_reg;
    logic [CNT_W-1:0]   div_reg;

    logic [CNT_W:0]     trial;
    logic               ge;
    logic [CNT_W:0]     diff;

    always_comb begin
        trial = {rem_reg, mag_reg[SUM_W-1]};
        ge    = (trial >= {1'b0, div_reg});
        diff  = trial - {1'b0, div_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(SUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // magnitude shifts out at the top while quotient bits shift in below
    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= dividend[SUM_W-1];
            mag_reg <= dividend[SUM_W-1] ? (~dividend + SUM_W'(1)) : dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end else if (busy_reg) begin
            mag_reg <= {mag_reg[SUM_W-2:0], ge};
            rem_reg <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~mag_reg[DELTA_W-1:0] + DELTA_W'(1))
                              : mag_reg[DELTA_W-1:0];

endmodule

>>> src/windowed_velocity_estimator_top.sv
// ----------------------------------------------------------------------------
// windowed_velocity_estimator_top
// moving-average displacement of a tracked box over a ring of recent deltas
// ----------------------------------------------------------------------------
// usage
//   s_ channel: one box request per frame, s_tdata = pos_x, pos_y, box_width,
//   box_height. m_ channel: one result per box, m_tdata = avg_dx, avg_dy,
//   m_tuser = status, avg_updated. cfg_ channel writes window_len (clamped
//   to 2..MAX_WINDOW in use); write it only while the block is idle.
//   the displacement ring sits in one ram; replacing the oldest entry takes
//   a read of that entry before the sums are updated and the new delta
//   written. whenever the mean is recomputed, a bit-serial divider does it
//   (one quotient bit per cycle, both axes in parallel). one box is in
//   work at a time, s_tready rises again together with m_tvalid. a stalled
//   receiver holds the result in the output register; the next box is
//   still taken and worked, and its result waits until the register frees.
//   reset clears the previous position, the counts, sums and held mean and
//   sets window_len to 8; the ring itself needs no clearing since only
//   written entries are ever read.
// ----------------------------------------------------------------------------
module windowed_velocity_estimator_top import wvel_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // box requests
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [11:0] pos_x, [23:12] pos_y, [35:24] box_width, [47:36] box_height
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // results
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [12:0] avg_dx, [25:13] avg_dy, [31:26] zero
    output logic [M_TDATA_W-1:0]  m_tdata,
    // [0] status, [1] avg_updated
    output logic [M_TUSER_W-1:0]  m_tuser,
    // window length register
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [WLEN_W-1:0]     cfg_data
);

    state_t state_reg, state_next;

    // config
    logic [WLEN_W-1:0] wlen_reg;

    // latched request
    logic [POS_W-1:0] x_reg, y_reg, w_reg, h_reg;

    // tracking state
    logic [POS_W-1:0]          prev_x_reg, prev_y_reg;
    logic                      have_prev_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [IDX_W-1:0]          head_reg;
    logic signed [SUM_W-1:0]   sum_dx_reg, sum_dy_reg;
    logic signed [DELTA_W-1:0] held_dx_reg, held_dy_reg;
    logic signed [DELTA_W-1:0] dx_reg, dy_reg;
    logic                      status_reg;
    logic                      updated_reg;

    // output register
    logic                  m_tvalid_reg;
    logic [M_TDATA_W-1:0]  m_tdata_reg;
    logic [M_TUSER_W-1:0]  m_tuser_reg;

    // evaluation of the latched box
    logic                      reject;
    logic                      d_valid;
    logic signed [DELTA_W-1:0] dx, dy;
    logic                      nz;
    logic [CNT_W-1:0]          eff_len;
    logic                      fill;
    logic [CNT_W:0]            slot_sum;
    logic [IDX_W-1:0]          slot_fill;
    logic [IDX_W-1:0]          head_inc;
    logic [CNT_W:0]            repl_sum;
    logic [IDX_W-1:0]          slot_repl;

    // ram and divider control
    logic                      ram_we, ram_re;
    logic [IDX_W-1:0]          ram_waddr;
    logic [RAM_W-1:0]          ram_wdata;
    logic [RAM_W-1:0]          ram_rdata;
    logic signed [DELTA_W-1:0] old_dx, old_dy;
    logic                      div_start;
    logic                      div_done_x, div_done_y, div_done;
    logic signed [DELTA_W-1:0] q_dx, q_dy;
    logic                      out_free;
    logic                      out_load;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wlen_reg <= WLEN_RESET;
        end else if (cfg_valid) begin
            wlen_reg <= cfg_data;
        end
    end

    // effective window length, clamped to 2..MAX_WINDOW
    always_comb begin
        if (CMP_W'(wlen_reg) < CMP_W'(2)) begin
            eff_len = CNT_W'(2);
        end else if (CMP_W'(wlen_reg) > CMP_W'(MAX_WINDOW)) begin
            eff_len = CNT_W'(MAX_WINDOW);
        end else begin
            eff_len = CNT_W'(wlen_reg);
        end
    end

    always_comb begin
        reject  = ((x_reg == '0) && (y_reg == '0)) || ((w_reg == '0) && (h_reg == '0));
        d_valid = !reject && have_prev_reg;
        dx      = $signed({1'b0, x_reg}) - $signed({1'b0, prev_x_reg});
        dy      = $signed({1'b0, y_reg}) - $signed({1'b0, prev_y_reg});
        nz      = (dx != '0) || (dy != '0);
        fill    = (count_reg < eff_len);

        // ring slot after the newest entry, modulo the depth
        slot_sum = (CNT_W + 1)'(head_reg) + (CNT_W + 1)'(count_reg);
        if (slot_sum >= (CNT_W + 1)'(MAX_WINDOW)) begin
            slot_sum = slot_sum - (CNT_W + 1)'(MAX_WINDOW);
        end
        slot_fill = slot_sum[IDX_W-1:0];

        // on replacement the head moves on and the newest lands at the tail
        if (head_reg == IDX_W'(MAX_WINDOW - 1)) begin
            head_inc = '0;
        end else begin
            head_inc = head_reg + IDX_W'(1);
        end
        repl_sum = (CNT_W + 1)'(head_inc) + (CNT_W + 1)'(count_reg) - (CNT_W + 1)'(1);
        if (repl_sum >= (CNT_W + 1)'(MAX_WINDOW)) begin
            repl_sum = repl_sum - (CNT_W + 1)'(MAX_WINDOW);
        end
        slot_repl = repl_sum[IDX_W-1:0];
    end

    assign old_dx   = ram_rdata[DELTA_W-1:0];
    assign old_dy   = ram_rdata[RAM_W-1:DELTA_W];
    assign out_free = !m_tvalid_reg || m_tready;
    assign div_done = div_done_x && div_done_y;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_EVAL;
            end
            ST_EVAL: begin
                priority if (!d_valid) state_next = ST_OUT;
                else if (nz && !fill)  state_next = ST_SUB;
                else                   state_next = ST_CHECK;
            end
            ST_SUB: begin
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (count_reg >= CNT_W'(2)) state_next = ST_DIV;
                else                        state_next = ST_OUT;
            end
            ST_DIV: begin
                if (div_done) state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_tready  = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = slot_fill;
        ram_wdata = {dy_reg, dx_reg};
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
            end
            ST_EVAL: begin
                // new entry into a free slot, or fetch the oldest to retire it
                ram_we    = d_valid && nz && fill;
                ram_re    = d_valid && nz && !fill;
                ram_waddr = slot_fill;
                ram_wdata = {dy, dx};
            end
            ST_SUB: begin
                ram_we    = 1'b1;
                ram_waddr = slot_repl;
            end
            ST_CHECK: begin
                div_start = (count_reg >= CNT_W'(2));
            end
            ST_DIV: begin
            end
            ST_OUT: begin
                out_load = out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // request latch
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            x_reg <= s_tdata[11:0];
            y_reg <= s_tdata[23:12];
            w_reg <= s_tdata[35:24];
            h_reg <= s_tdata[47:36];
        end
    end

    // tracking state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            have_prev_reg <= 1'b0;
            count_reg     <= '0;
            head_reg      <= '0;
            sum_dx_reg    <= '0;
            sum_dy_reg    <= '0;
            held_dx_reg   <= '0;
            held_dy_reg   <= '0;
            status_reg    <= 1'b0;
            updated_reg   <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_EVAL: begin
                    status_reg  <= d_valid;
                    updated_reg <= 1'b0;
                    dx_reg      <= dx;
                    dy_reg      <= dy;
                    if (!reject) begin
                        prev_x_reg    <= x_reg;
                        prev_y_reg    <= y_reg;
                        have_prev_reg <= 1'b1;
                    end
                    if (d_valid && nz && fill) begin
                        count_reg  <= count_reg + CNT_W'(1);
                        sum_dx_reg <= sum_dx_reg + SUM_W'(dx);
                        sum_dy_reg <= sum_dy_reg + SUM_W'(dy);
                    end
                end
                ST_SUB: begin
                    // retire the oldest entry, count stays
                    head_reg   <= head_inc;
                    sum_dx_reg <= sum_dx_reg - SUM_W'(old_dx) + SUM_W'(dx_reg);
                    sum_dy_reg <= sum_dy_reg - SUM_W'(old_dy) + SUM_W'(dy_reg);
                end
                ST_DIV: begin
                    if (div_done) begin
                        held_dx_reg <= q_dx;
                        held_dy_reg <= q_dy;
                        updated_reg <= 1'b1;
                    end
                end
                ST_IDLE, ST_CHECK, ST_OUT: begin
                end
                default: begin
                end
            endcase
        end
    end

    // output register, holds while the receiver stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {(M_TDATA_W - RAM_W)'(0), held_dy_reg, held_dx_reg};
            m_tuser_reg <= {updated_reg, status_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // displacement ring
    wvel_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    // per-axis mean
    wvel_div u_div_x (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_dx_reg),
        .divisor  (count_reg),
        .done     (div_done_x),
        .quotient (q_dx)
    );

    wvel_div u_div_y (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_dy_reg),
        .divisor  (count_reg),
        .done     (div_done_y),
        .quotient (q_dy)
    );

    // checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_WINDOW))
        else $error("delta count beyond window depth");

    a_updated_needs_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tuser[0])
        else $error("mean updated without a displacement");

    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while one is in work");

    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done_x |-> (state_reg == ST_DIV) && div_done_y)
        else $error("divider finished outside the divide step");

endmodule

>>> tb/sv/tb_windowed_velocity_estimator_top.sv
// ----------------------------------------------------------------------------
// tb_windowed_velocity_estimator_top
// self-checking bench for the windowed velocity estimator
// ----------------------------------------------------------------------------
// box requests go in on the s_ stream and an in-bench predictor keeps its own
// previous position, displacement ring, sums and held mean. every accepted
// result on the m_ stream is compared against the oldest prediction. the run
// opens with directed boxes (rejections, first box, zero and full-scale
// displacements), then walks random tracks through a series of window
// lengths, in-range and out-of-range, with random idling on both streams.
// ----------------------------------------------------------------------------
module tb_windowed_velocity_estimator_top import wvel_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int PHASE_BOXES = 150;
    localparam int TAIL_CYCLES = 40;

    // s_tdata layout, last field in the low bits
    typedef struct packed {
        logic [POS_W-1:0] box_height;
        logic [POS_W-1:0] box_width;
        logic [POS_W-1:0] pos_y;
        logic [POS_W-1:0] pos_x;
    } box_t;

    typedef struct packed {
        logic                      status;
        logic                      avg_updated;
        logic signed [DELTA_W-1:0] avg_dx;
        logic signed [DELTA_W-1:0] avg_dy;
    } motion_t;

    class velocity_scoreboard;
        logic [POS_W-1:0]          last_x, last_y;
        bit                        have_last;
        logic signed [DELTA_W-1:0] ring_dx [MAX_WINDOW];
        logic signed [DELTA_W-1:0] ring_dy [MAX_WINDOW];
        int unsigned               fill, head;
        int                        sum_x, sum_y;
        logic signed [DELTA_W-1:0] mean_dx, mean_dy;
        logic [WLEN_W-1:0]         win_len;
        motion_t                   pending [$];
        int                        mismatches;

        function new();
            last_x     = '0;
            last_y     = '0;
            have_last  = 1'b0;
            fill       = 0;
            head       = 0;
            sum_x      = 0;
            sum_y      = 0;
            mean_dx    = '0;
            mean_dy    = '0;
            win_len    = WLEN_RESET;
            mismatches = 0;
        endfunction

        function void set_window(logic [WLEN_W-1:0] len);
            win_len = len;
        endfunction

        // work out the result of one accepted box request
        function void note_box(box_t b);
            motion_t     m;
            int          dx, dy;
            int unsigned lim, slot;
            m.status      = 1'b0;
            m.avg_updated = 1'b0;
            lim = (win_len < 2) ? 2 : ((win_len > MAX_WINDOW) ? MAX_WINDOW : win_len);
            if (!((b.pos_x == 0 && b.pos_y == 0) ||
                  (b.box_width == 0 && b.box_height == 0))) begin
                if (have_last) begin
                    dx = int'(b.pos_x) - int'(last_x);
                    dy = int'(b.pos_y) - int'(last_y);
                    m.status = 1'b1;
                    if (dx != 0 || dy != 0) begin
                        if (fill < lim) begin
                            slot = (head + fill) % MAX_WINDOW;
                            fill++;
                        end else begin
                            // drop the oldest, the count never shrinks
                            sum_x -= ring_dx[head];
                            sum_y -= ring_dy[head];
                            head = (head + 1) % MAX_WINDOW;
                            slot = (head + fill - 1) % MAX_WINDOW;
                        end
                        ring_dx[slot] = dx;
                        ring_dy[slot] = dy;
                        sum_x += dx;
                        sum_y += dy;
                    end
                    if (fill >= 2) begin
                        mean_dx = sum_x / int'(fill);
                        mean_dy = sum_y / int'(fill);
                        m.avg_updated = 1'b1;
                    end
                end
                last_x    = b.pos_x;
                last_y    = b.pos_y;
                have_last = 1'b1;
            end
            m.avg_dx = mean_dx;
            m.avg_dy = mean_dy;
            pending = {pending, m};
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] tdata, logic [M_TUSER_W-1:0] tuser);
            motion_t want, got;
            got.status      = tuser[0];
            got.avg_updated = tuser[1];
            got.avg_dx      = tdata[DELTA_W-1:0];
            got.avg_dy      = tdata[2*DELTA_W-1:DELTA_W];
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with nothing pending: status %0b upd %0b dx %0d dy %0d",
                             $time, got.status, got.avg_updated, got.avg_dx, got.avg_dy);
                return;
            end
            want = pending.pop_front();
            if (got !== want || tdata[M_TDATA_W-1:2*DELTA_W] !== '0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: want %0b %0b %0d %0d, got %0b %0b %0d %0d pad %h",
                             $time, want.status, want.avg_updated, want.avg_dx, want.avg_dy,
                             got.status, got.avg_updated, got.avg_dx, got.avg_dy,
                             tdata[M_TDATA_W-1:2*DELTA_W]);
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [WLEN_W-1:0]    cfg_data;

    velocity_scoreboard sb = new();

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int stall_left   = 0;
    int cycles       = 0;

    // random track state
    int cur_x = 80;
    int cur_y = 2970;
    int vel_x = 7;
    int vel_y = -3;

    windowed_velocity_estimator_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 75)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int tx_gap();
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
            return pick_gap();
        return 0;
    endfunction

    function automatic box_t mk_box(int x, int y, int w, int h);
        box_t b;
        b.pos_x      = POS_W'(x);
        b.pos_y      = POS_W'(y);
        b.box_width  = POS_W'(w);
        b.box_height = POS_W'(h);
        return b;
    endfunction

    // next box of a wandering track, with rejections, jumps and pauses mixed in
    function automatic box_t next_box();
        box_t b;
        int   r, sz, nx, ny;
        sz = $urandom_range(99);
        b.box_width  = POS_W'($urandom);
        b.box_height = POS_W'($urandom);
        if (sz < 10)
            b.box_width = '0;
        else if (sz < 20)
            b.box_height = '0;
        r = $urandom_range(99);
        if (r < 4) begin
            b.pos_x = '0;
            b.pos_y = '0;
            return b;
        end
        if (r < 8) begin
            b.pos_x      = POS_W'($urandom);
            b.pos_y      = POS_W'($urandom);
            b.box_width  = '0;
            b.box_height = '0;
            return b;
        end
        if (r < 14) begin
            cur_x = int'($urandom_range(0, 4095));
            cur_y = int'($urandom_range(0, 4095));
        end else if (r >= 20) begin
            if (r < 24) begin
                vel_x = int'($urandom_range(0, 400)) - 200;
                vel_y = int'($urandom_range(0, 400)) - 200;
            end
            nx = cur_x + vel_x + int'($urandom_range(0, 4)) - 2;
            ny = cur_y + vel_y + int'($urandom_range(0, 4)) - 2;
            if (nx < 0 || nx > 4095) begin
                vel_x = -vel_x;
                nx = (nx < 0) ? 0 : 4095;
            end
            if (ny < 0 || ny > 4095) begin
                vel_y = -vel_y;
                ny = (ny < 0) ? 0 : 4095;
            end
            cur_x = nx;
            cur_y = ny;
        end
        b.pos_x = POS_W'(cur_x);
        b.pos_y = POS_W'(cur_y);
        return b;
    endfunction

    // one box request; valid stays up across back-to-back requests
    task automatic send_box(box_t b, int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        sb.note_box(b);
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
    endtask

    task automatic write_window(logic [WLEN_W-1:0] len);
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_window(len);
    endtask

    // result side back-pressure
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else if (rx_stall_pct != 0 && $urandom_range(99) < rx_stall_pct) begin
            m_tready <= 1'b0;
            stall_left = pick_gap() - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        box_t              dir_boxes [$];
        logic [WLEN_W-1:0] lengths [$];
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        m_tready  <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed boxes under the reset window length
        dir_boxes = {dir_boxes, mk_box(0, 0, 10, 10)};           // origin, nothing tracked yet
        dir_boxes = {dir_boxes, mk_box(100, 200, 0, 0)};         // zero size
        dir_boxes = {dir_boxes, mk_box(100, 200, 16, 16)};       // first accepted box
        dir_boxes = {dir_boxes, mk_box(100, 200, 16, 16)};       // no motion, empty window
        dir_boxes = {dir_boxes, mk_box(4095, 4095, 4095, 4095)}; // one delta, mean held
        dir_boxes = {dir_boxes, mk_box(0, 4095, 0, 7)};          // full negative x step
        dir_boxes = {dir_boxes, mk_box(4095, 0, 5, 0)};          // full positive x, negative y
        dir_boxes = {dir_boxes, mk_box(0, 0, 4095, 4095)};       // origin with a size
        dir_boxes = {dir_boxes, mk_box(4095, 0, 0, 0)};          // zero size
        dir_boxes = {dir_boxes, mk_box(4095, 0, 1, 1)};          // no motion, mean recomputed
        dir_boxes = {dir_boxes, mk_box(1, 1, 2048, 2048)};
        // steady drift past the window
        for (int k = 1; k <= 10; k++)
            dir_boxes = {dir_boxes, mk_box(10 + 7 * k, 3000 - 3 * k, 40, 30)};
        tx_idle_pct  = 30;
        rx_stall_pct = 30;
        foreach (dir_boxes[i])
            send_box(dir_boxes[i], tx_gap());
        wait_drain();

        // window lengths: extremes, out of range both ways, shrink below the fill
        lengths = '{5'd2, 5'd16, 5'd0, 5'd31, 5'd1, 5'd17, 5'd5, 5'd16, 5'd3};
        lengths = {lengths, WLEN_W'($urandom_range(0, 31))};
        lengths = {lengths, 5'd12};
        lengths = {lengths, WLEN_W'($urandom_range(2, 16))};

        foreach (lengths[p]) begin
            write_window(lengths[p]);
            tx_idle_pct  = (p % 3 == 0) ? 0 : $urandom_range(10, 60);
            rx_stall_pct = (p % 3 == 0) ? 0 : $urandom_range(10, 60);
            repeat (PHASE_BOXES) begin
                if ($urandom_range(99) == 0)
                    wait_drain();
                send_box(next_box(), tx_gap());
            end
            wait_drain();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
